>>> src/midi_pkg.sv
// Shared types and byte codes for the MIDI byte stream parser.
package midi_pkg;

  // Kind of a result word.
  typedef enum logic [1:0] {
    KindMsg     = 2'd0,
    KindSxData  = 2'd1,
    KindSxCmd   = 2'd2,
    KindSxUser  = 2'd3
  } kind_e;

  localparam int unsigned CountW = 13;

  localparam logic [7:0] SysexStart   = 8'hF0;
  localparam logic [7:0] SysexEnd     = 8'hF7;
  localparam logic [7:0] TimingClock  = 8'hF8;
  localparam logic [7:0] TimeCode     = 8'hF1;
  localparam logic [7:0] SongPosition = 8'hF2;
  localparam logic [7:0] SongSelect   = 8'hF3;
  localparam logic [7:0] CmdPrefix0   = 8'h00;
  localparam logic [7:0] CmdPrefix1   = 8'h03;
  localparam logic [7:0] CmdPrefix2   = 8'h45;

  // One result word.
  typedef struct packed {
    kind_e              kind;
    logic [7:0]         status_byte;
    logic [6:0]         first_data;
    logic [6:0]         second_data;
    logic [1:0]         message_length;
    logic [CountW-1:0]  sysex_count;
    logic               sysex_overflow;
  } result_t;

endpackage

>>> src/midi_byte_stream_parser.sv
// MIDI byte stream parser: running status, sysex pass-through, USB packet skip.
//
// Usage:
//   Feed one raw MIDI byte per word on the slave stream. tuser marks whether
//   the byte came from a 3-byte USB MIDI packet and whether it is the first
//   payload byte of that packet. Each accepted word yields zero or one result
//   word on the master stream: a complete channel or system message, a sysex
//   data byte with its index, or a sysex end event (command or user).
//   A result appears on the master side in the cycle after its input word
//   is accepted. Throughput: one byte per cycle when not stalled; decoding
//   is combinational from the input handshake to the result register.
//   Stall: while a result word is held and the master side is not ready,
//   the slave side stops taking bytes; the held result stays unchanged.
//   Reset (rst_ni low, asynchronous) clears running status, sysex tracking,
//   the packet skip flag and the result valid.
//   SYSEX_MAX bounds the stored sysex length; bytes past it are dropped and
//   the end event reports the overflow.
module midi_byte_stream_parser
  import midi_pkg::*;
#(
  parameter int unsigned SYSEX_MAX = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_in
  input  logic [1:0]  s_axis_tuser_i,   // [0] from_usb, [1] packet_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] status_byte, [14:8] first_data, [21:15] second_data,
  // [23:22] message_length, [36:24] sysex_count, [37] sysex_overflow, [39:38] zero
  output logic [39:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o    // [1:0] kind
);

  localparam int unsigned LenW = $clog2(SYSEX_MAX + 1);
  localparam logic [LenW-1:0] LenMax = LenW'(SYSEX_MAX);
  localparam logic [LenW-1:0] PrefixLen = LenW'(3);

  // Parser state.
  logic [7:0]      run_status_q, run_status_d;
  logic [6:0]      held_data_q, held_data_d;
  logic            await_second_q, await_second_d;
  logic            in_sysex_q, in_sysex_d;
  logic [LenW-1:0] sx_len_q, sx_len_d;
  logic [7:0]      prefix_q [3];
  logic [7:0]      prefix_d [3];
  logic            overflow_q, overflow_d;
  logic            skip_q, skip_d;

  // Result register.
  logic            out_valid_q;
  result_t         out_q;

  logic            in_accept;
  logic [7:0]      in_byte;
  logic            in_usb;
  logic            in_start;
  logic            skip_now;
  logic            res_valid;
  result_t         res;
  logic [3:0]      hi_nib;
  logic            two_data;
  logic            one_data;
  logic            single_byte;
  logic            is_cmd;
  logic [LenW+CountW-1:0] len_ext;

  assign in_byte  = s_axis_tdata_i;
  assign in_usb   = s_axis_tuser_i[0];
  assign in_start = s_axis_tuser_i[1];

  // Take a byte whenever the result slot is empty or being drained.
  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign in_accept       = s_axis_tvalid_i & s_axis_tready_o;

  assign hi_nib   = run_status_q[7:4];
  assign two_data = (hi_nib == 4'h8) || (hi_nib == 4'h9) || (hi_nib == 4'hA) ||
                    (hi_nib == 4'hB) || (hi_nib == 4'hE) ||
                    (run_status_q == SongPosition);
  assign one_data = (hi_nib == 4'hC) || (hi_nib == 4'hD) ||
                    (run_status_q == SongSelect) || (run_status_q == TimeCode);
  assign single_byte = ((in_byte >= 8'hF4) && (in_byte <= 8'hF6)) || (in_byte >= 8'hF9);
  assign is_cmd = (prefix_q[0] == CmdPrefix0) && (prefix_q[1] == CmdPrefix1) &&
                  (prefix_q[2] == CmdPrefix2);

  // Report the low count bits whatever the length width.
  assign len_ext = {{CountW{1'b0}}, sx_len_q};

  // A USB byte that is not a packet start stays skipped while the flag is up.
  assign skip_now = skip_q & in_usb & ~in_start;

  always_comb begin
    run_status_d   = run_status_q;
    held_data_d    = held_data_q;
    await_second_d = await_second_q;
    in_sysex_d     = in_sysex_q;
    sx_len_d       = sx_len_q;
    prefix_d       = prefix_q;
    overflow_d     = overflow_q;
    skip_d         = skip_q;
    res_valid      = 1'b0;
    res            = '0;

    if (in_accept) begin
      skip_d = skip_now;
      if (!skip_now) begin
        if (in_sysex_q) begin
          if (in_byte == SysexEnd) begin
            in_sysex_d = 1'b0;
            if (sx_len_q > PrefixLen) begin
              res_valid          = 1'b1;
              res.kind           = is_cmd ? KindSxCmd : KindSxUser;
              res.status_byte    = SysexEnd;
              res.sysex_count    = len_ext[CountW-1:0];
              res.sysex_overflow = overflow_q;
            end
          end else if (sx_len_q >= LenMax) begin
            // Drop: the store is full.
            overflow_d = 1'b1;
          end else begin
            if (sx_len_q < PrefixLen) begin
              prefix_d[sx_len_q[1:0]] = in_byte;
            end
            res_valid       = 1'b1;
            res.kind        = KindSxData;
            res.status_byte = in_byte;
            res.sysex_count = len_ext[CountW-1:0];
            sx_len_d        = sx_len_q + LenW'(1);
          end
        end else if (in_byte[7]) begin
          // Any status byte restarts sysex tracking and sets running status.
          sx_len_d     = '0;
          prefix_d     = '{default: '0};
          overflow_d   = 1'b0;
          run_status_d = in_byte;
          if (single_byte) begin
            res_valid          = 1'b1;
            res.kind           = KindMsg;
            res.status_byte    = in_byte;
            res.message_length = 2'd1;
            skip_d             = in_usb;
          end else if (in_byte == SysexStart) begin
            in_sysex_d = 1'b1;
          end else if (in_byte == TimingClock) begin
            skip_d = in_usb;
          end
        end else if (two_data) begin
          if (!await_second_q) begin
            held_data_d    = in_byte[6:0];
            await_second_d = 1'b1;
          end else begin
            await_second_d     = 1'b0;
            res_valid          = 1'b1;
            res.kind           = KindMsg;
            res.status_byte    = run_status_q;
            res.first_data     = held_data_q;
            res.second_data    = in_byte[6:0];
            res.message_length = 2'd3;
          end
        end else if (one_data) begin
          res_valid          = 1'b1;
          res.kind           = KindMsg;
          res.status_byte    = run_status_q;
          res.first_data     = in_byte[6:0];
          res.message_length = 2'd2;
          skip_d             = in_usb;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_status_q   <= '0;
      held_data_q    <= '0;
      await_second_q <= 1'b0;
      in_sysex_q     <= 1'b0;
      sx_len_q       <= '0;
      prefix_q       <= '{default: '0};
      overflow_q     <= 1'b0;
      skip_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      run_status_q   <= run_status_d;
      held_data_q    <= held_data_d;
      await_second_q <= await_second_d;
      in_sysex_q     <= in_sysex_d;
      sx_len_q       <= sx_len_d;
      prefix_q       <= prefix_d;
      overflow_q     <= overflow_d;
      skip_q         <= skip_d;
      if (in_accept) begin
        out_valid_q <= res_valid;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: load on every accepted byte, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = {2'b00, out_q.sysex_overflow, out_q.sysex_count,
                            out_q.message_length, out_q.second_data,
                            out_q.first_data, out_q.status_byte};

  // Stored sysex length never passes its bound.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sx_len_q <= LenMax)
    else $error("sysex length past bound");

  // A status byte taken outside sysex clears the stored length.
  a_status_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !skip_now && !in_sysex_q && in_byte[7]) |=> (sx_len_q == '0))
    else $error("status byte did not clear sysex length");

  // A held sysex data word was produced while sysex was open.
  a_sx_data_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.kind == KindSxData)) |-> $past(in_sysex_q))
    else $error("sysex data word outside sysex");

  // A message word always carries a length and no sysex fields.
  a_msg_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.kind == KindMsg)) |->
      (out_q.message_length != 2'd0 && out_q.sysex_count == '0 && !out_q.sysex_overflow))
    else $error("malformed message word");

endmodule
